/* sv/sspg_pkg.sv */
`timescale 1ns / 1ps
package sspg_pkg;
	localparam int SAMPLE_BITS = 24;
	localparam int GAIN_FRAC_BITS = 16;
	localparam int HOLD_BITS = 24;
	localparam int GAIN_BITS = GAIN_FRAC_BITS + 1;
	localparam int HP_BITS = 32;
	localparam int COEF_BITS = 24;
	localparam int TRIP_BITS = 23;
	localparam int IDX_BITS = 3;
	localparam int CFG_BITS = 24;
	localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;
	localparam logic [GAIN_BITS-1:0] GAIN_EPS = GAIN_BITS'((1 << GAIN_FRAC_BITS) / 10000);
	localparam logic [SAMPLE_BITS-1:0] ONE_Q = SAMPLE_BITS'(1) << (SAMPLE_BITS - 4);
	localparam int NUM_BITS = SAMPLE_BITS - 4 + GAIN_FRAC_BITS + 1;

	localparam logic [IDX_BITS-1:0] REG_HP_POLE = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_HP_GAIN = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_HP_TRIP = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_DROP_STEP = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_HOLD_LEN = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_RISE_STEP = 3'd5;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_DROP = 2'd1;
	localparam logic [1:0] MODE_HOLD = 2'd2;
	localparam logic [1:0] MODE_RISE = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
		logic left_invalid;
		logic right_invalid;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic signed [SAMPLE_BITS-1:0] mono_out;
		logic [GAIN_BITS-1:0] gain_now;
		logic [1:0] mode_now;
	} out_t;
endpackage

/* sv/sspg_if.sv */
`timescale 1ns / 1ps
interface sspg_in_if;
	logic valid;
	logic ready;
	sspg_pkg::in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sspg_out_if;
	logic valid;
	logic ready;
	sspg_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/sspg_serial_mac.sv */
`timescale 1ns / 1ps
// Bit-serial signed multiply: a (signed) times b (unsigned), one bit of b per cycle.
module sspg_serial_mac (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [sspg_pkg::HP_BITS:0] a,
	input logic [sspg_pkg::COEF_BITS-1:0] b,
	output logic done,
	output logic signed [sspg_pkg::HP_BITS+sspg_pkg::COEF_BITS+1:0] prod
);
	import sspg_pkg::*;
	localparam int PW = HP_BITS + COEF_BITS + 2;
	localparam int CW = $clog2(COEF_BITS + 1);

	logic [COEF_BITS-1:0] b_q;
	logic signed [PW-1:0] a_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;

	// shift-add, multiplicand moves up one place per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(COEF_BITS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			b_q <= b;
			a_q <= PW'(a);
			prod <= '0;
		end else if (busy_q) begin
			if (b_q[0]) prod <= prod + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end
endmodule

/* sv/stereo_speaker_protect_gate_core.sv */
`timescale 1ns / 1ps
// Steps from the accepting edge to a valid result: two bit-serial high-pass
// multiplies, the restoring divider, the output gain multiply and the filter update,
// gain select and output steps.
// One item in flight; the next request is taken the cycle after the result is posted.
// A waiting result stalls only the final step, not the input.
// Reset (arst_n low, asynchronous): idle mode, unity gain, filter state zero, defaults.
module stereo_speaker_protect_gate_core (
	input logic clk,
	input logic arst_n,
	sspg_in_if.sink in_ch,
	sspg_out_if.source out_ch,
	input logic cfg_we,
	input logic [sspg_pkg::IDX_BITS-1:0] cfg_index,
	input logic [sspg_pkg::CFG_BITS-1:0] cfg_data
);
	import sspg_pkg::*;
	localparam int PW = HP_BITS + COEF_BITS + 2;
	localparam int DW = $clog2(NUM_BITS + 1);
	localparam int MW = $clog2(GAIN_BITS + 1);
	localparam int OW = SAMPLE_BITS + GAIN_BITS + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_HP, ST_DIV, ST_GAIN, ST_MULO, ST_OUT
	} state_t;

	state_t state_q;
	logic [COEF_BITS-1:0] pole_q, bgain_q;
	logic [TRIP_BITS-1:0] trip_q;
	logic [GAIN_BITS-1:0] dstep_q, rstep_q;
	logic [HOLD_BITS-1:0] hlen_q, hold_q;
	logic [1:0] mode_q;
	logic [GAIN_BITS-1:0] slew_q, g_q;
	logic signed [SAMPLE_BITS-1:0] last_in_q, l_q, r_q, mono_q;
	logic signed [HP_BITS-1:0] last_out_q;
	logic inv_q, hot_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic signed [PW-1:0] acc_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [SAMPLE_BITS:0] rem_q;
	logic [DW-1:0] dcnt_q;
	logic [GAIN_BITS-1:0] mb_q;
	logic [MW-1:0] mcnt_q;
	logic signed [OW-1:0] pl_q, pr_q, al_q, ar_q;
	logic out_v_q;
	out_t out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q <= 24'd14549379; bgain_q <= 24'd15663302; trip_q <= 23'd2092184;
			dstep_q <= 17'd186; hlen_q <= HOLD_BITS'(14685); rstep_q <= 17'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HP_POLE: pole_q <= cfg_data[COEF_BITS-1:0];
				REG_HP_GAIN: bgain_q <= cfg_data[COEF_BITS-1:0];
				REG_HP_TRIP: trip_q <= cfg_data[TRIP_BITS-1:0];
				REG_DROP_STEP: dstep_q <= cfg_data[GAIN_BITS-1:0];
				REG_HOLD_LEN: hlen_q <= cfg_data[HOLD_BITS-1:0];
				REG_RISE_STEP: rstep_q <= cfg_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input decode
	logic signed [SAMPLE_BITS-1:0] li, ri;
	logic [SAMPLE_BITS-1:0] ali, ari, pki;
	logic signed [SAMPLE_BITS:0] sum_i;
	always_comb begin
		li = in_ch.data.left_invalid ? '0 : in_ch.data.left_sample;
		ri = in_ch.data.right_invalid ? '0 : in_ch.data.right_sample;
		ali = li[SAMPLE_BITS-1] ? SAMPLE_BITS'(-li) : li;
		ari = ri[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ri) : ri;
		pki = (ali > ari) ? ali : ari;
		sum_i = {li[SAMPLE_BITS-1], li} + {ri[SAMPLE_BITS-1], ri};
	end

	// result register parts input from output
	assign in_ch.ready = (state_q == ST_IDLE);

	// shared serial multiplier
	logic m_start, m_done;
	logic signed [HP_BITS:0] m_a;
	logic [COEF_BITS-1:0] m_b;
	logic signed [PW-1:0] m_prod;
	sspg_serial_mac u_mac (.clk, .arst_n, .start(m_start), .a(m_a), .b(m_b),
		.done(m_done), .prod(m_prod));

	always_comb begin
		m_start = 1'b0;
		m_a = (HP_BITS+1)'(mono_q) - (HP_BITS+1)'(last_in_q);
		m_b = bgain_q;
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
			m_start = 1'b1;
			m_a = (HP_BITS+1)'(sum_i >>> 1) - (HP_BITS+1)'(last_in_q);
		end else if (state_q == ST_MUL1 && m_done) begin
			m_start = 1'b1;
			m_a = (HP_BITS+1)'(last_out_q);
			m_b = pole_q;
		end
	end

	// filter result with rounding and saturation
	logic signed [PW-1:0] hp_full;
	logic signed [HP_BITS-1:0] hp_sat;
	logic [HP_BITS-1:0] hp_abs;
	always_comb begin
		hp_full = (acc_q + m_prod + (PW'(1) <<< 23)) >>> 24;
		if (hp_full > PW'(32'sh7FFFFFFF)) hp_sat = 32'sh7FFFFFFF;
		else if (hp_full < -PW'(64'sh80000000)) hp_sat = 32'sh80000000;
		else hp_sat = hp_full[HP_BITS-1:0];
		hp_abs = hp_sat[HP_BITS-1] ? HP_BITS'(-hp_sat) : hp_sat;
	end

	// divider trial subtract
	logic [SAMPLE_BITS:0] rem_sh;
	logic [DW-1:0] dbit;
	always_comb begin
		dbit = DW'(NUM_BITS - 1) - dcnt_q;
		rem_sh = {rem_q[SAMPLE_BITS-1:0], (dbit == DW'(NUM_BITS - 1))};
	end

	// gain slew step
	logic [GAIN_BITS-1:0] ds, rs, ns;
	logic [1:0] nm;
	always_comb begin
		ds = (dstep_q == '0) ? GAIN_BITS'(1) : dstep_q;
		rs = (rstep_q == '0) ? GAIN_BITS'(1) : rstep_q;
		ns = slew_q;
		nm = mode_q;
		case (mode_q)
			MODE_DROP: begin
				ns = (slew_q <= ds) ? '0 : slew_q - ds;
				if (ns <= GAIN_EPS) begin ns = '0; nm = MODE_HOLD; end
			end
			MODE_HOLD: begin
				ns = '0;
				if (hold_q <= HOLD_BITS'(1)) nm = MODE_RISE;
			end
			MODE_RISE: begin
				ns = (UNITY - slew_q <= rs) ? UNITY : slew_q + rs;
				if (ns >= UNITY - GAIN_EPS) begin ns = UNITY; nm = MODE_IDLE; end
			end
			default: begin ns = UNITY; nm = MODE_IDLE; end
		endcase
	end

	logic signed [OW-1:0] ol, orr;
	logic signed [SAMPLE_BITS-1:0] ols, ors;
	logic signed [SAMPLE_BITS:0] om;
	always_comb begin
		ol = (al_q + (OW'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
		orr = (ar_q + (OW'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
		ols = ol[SAMPLE_BITS-1:0];
		ors = orr[SAMPLE_BITS-1:0];
		om = ({ols[SAMPLE_BITS-1], ols} + {ors[SAMPLE_BITS-1], ors}) >>> 1;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_IDLE;
			slew_q <= UNITY;
			hold_q <= '0;
			last_in_q <= '0;
			last_out_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_ch.valid && in_ch.ready) begin
					l_q <= li; r_q <= ri;
					mono_q <= SAMPLE_BITS'(sum_i >>> 1);
					peak_q <= pki;
					inv_q <= in_ch.data.left_invalid | in_ch.data.right_invalid;
					state_q <= ST_MUL1;
				end
				ST_MUL1: if (m_done) begin
					acc_q <= m_prod;
					state_q <= ST_MUL2;
				end
				ST_MUL2: if (m_done) state_q <= ST_HP;
				ST_HP: begin
					last_out_q <= hp_sat;
					last_in_q <= mono_q;
					hot_q <= (peak_q > ONE_Q);
					if (hp_abs >= HP_BITS'(trip_q) || peak_q > ONE_Q || inv_q) begin
						mode_q <= MODE_DROP;
						hold_q <= (hlen_q == '0) ? HOLD_BITS'(1) : hlen_q;
					end
					rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (rem_sh >= {1'b0, peak_q}) begin
						rem_q <= rem_sh - {1'b0, peak_q};
						quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DW'(NUM_BITS - 1)) state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					slew_q <= ns;
					mode_q <= nm;
					if (mode_q == MODE_HOLD && hold_q != '0) hold_q <= hold_q - 1'b1;
					if (hot_q && (NUM_BITS)'(ns) > quo_q) g_q <= quo_q[GAIN_BITS-1:0];
					else g_q <= ns;
					if (hot_q && (NUM_BITS)'(ns) > quo_q) mb_q <= quo_q[GAIN_BITS-1:0];
					else mb_q <= ns;
					pl_q <= OW'(l_q); pr_q <= OW'(r_q);
					al_q <= '0; ar_q <= '0; mcnt_q <= '0;
					state_q <= ST_MULO;
				end
				ST_MULO: begin
					// one gain bit per cycle on both channels
					if (mb_q[0]) begin al_q <= al_q + pl_q; ar_q <= ar_q + pr_q; end
					pl_q <= pl_q <<< 1; pr_q <= pr_q <<< 1;
					mb_q <= mb_q >> 1;
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == MW'(GAIN_BITS - 1)) state_q <= ST_OUT;
				end
				ST_OUT: if (!out_v_q) begin
					out_q.left_out <= ols;
					out_q.right_out <= ors;
					out_q.mono_out <= om[SAMPLE_BITS-1:0];
					out_q.gain_now <= g_q;
					out_q.mode_now <= mode_q;
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;
endmodule

/* sv/sspg_checker.sv */
`timescale 1ns / 1ps
module sspg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [sspg_pkg::GAIN_BITS-1:0] gain_now,
	input logic [1:0] mode_now
);
	import sspg_pkg::*;
	// result stays valid and its gain holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gain_now)) else $error("stall");
	// one request at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	// gain never above unity
	a_gain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gain_now <= UNITY) else $error("gain");
	// hold mode shows zero gain
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_now == MODE_HOLD |-> gain_now == '0) else $error("hold gain");
endmodule

bind stereo_speaker_protect_gate_core sspg_checker u_chk (.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .gain_now(out_ch.data.gain_now),
	.mode_now(out_ch.data.mode_now));
